// File: hw/rtl/wsfhb_pkg.sv
// Shared types and constants for the unmasked WebSocket frame header builder.
`timescale 1ns / 1ps

package wsfhb_pkg;

  // Command codes carried by an input word.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Frame encoding constants.
  localparam logic [3:0] OPCODE_CLOSE = 4'd8;
  localparam logic [7:0] FIN_BIT      = 8'h80;
  localparam logic [6:0] LEN7_MAX     = 7'd125;
  localparam logic [7:0] LEN16_MARK   = 8'd126;
  localparam logic [7:0] LEN64_MARK   = 8'd127;
  localparam int unsigned CLOSE_EXTRA = 2;

  // Job queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Byte index within one job; a header has at most twelve bytes.
  localparam int unsigned MAX_JOB_BYTES = 12;
  localparam int unsigned IDX_W         = $clog2(MAX_JOB_BYTES);

  typedef enum logic [1:0] {
    LEN_FORM7,
    LEN_FORM16,
    LEN_FORM64
  } len_form_e;

  typedef enum logic {
    JOB_HEADER,
    JOB_DATA
  } job_kind_e;

  typedef struct packed {
    logic        command;
    logic [3:0]  opcode;
    logic [62:0] pay_len;
    logic [15:0] close_code;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       frame_end;
  } out_word_t;

  // One queued job: a whole header, or a single payload byte.
  typedef struct packed {
    job_kind_e   kind;
    logic [3:0]  opcode;
    len_form_e   form;
    logic        is_close;
    logic [63:0] hlen;
    logic [15:0] close_code;
    logic        empty;
    logic [7:0]  data_byte;
    logic        frame_end;
  } job_t;

endpackage

// File: hw/rtl/wsfhb_front.sv
// Front end: accepts words, tracks the open frame and classifies each word into a job.
`timescale 1ns / 1ps

module wsfhb_front import wsfhb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  input  logic     full_i,
  output logic     push_o,
  output job_t     job_o
);

  logic [62:0] remaining_q, remaining_d;
  logic        open_q, open_d;
  logic        accept;
  logic        is_close;
  logic [63:0] hlen;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Header length and its encoding form.
  always_comb begin
    is_close = (in_word_i.opcode == OPCODE_CLOSE);
    hlen     = {1'b0, in_word_i.pay_len}
             + (is_close ? 64'(CLOSE_EXTRA) : 64'd0);

    job_o            = '0;
    job_o.opcode     = in_word_i.opcode;
    job_o.is_close   = is_close;
    job_o.hlen       = hlen;
    job_o.close_code = in_word_i.close_code;
    job_o.empty      = (in_word_i.pay_len == 63'd0);
    job_o.data_byte  = in_word_i.data_byte;
    job_o.frame_end  = (remaining_q == 63'd1);
    if (hlen[63:7] == '0 && hlen[6:0] <= LEN7_MAX) begin
      job_o.form = LEN_FORM7;
    end else if (hlen[63:16] == '0) begin
      job_o.form = LEN_FORM16;
    end else begin
      job_o.form = LEN_FORM64;
    end
    job_o.kind = (in_word_i.command == CMD_DATA) ? JOB_DATA : JOB_HEADER;
  end

  // A data word with no open frame is dropped; everything else becomes a job.
  assign push_o = accept && (in_word_i.command == CMD_START || open_q);

  // Frame tracking.
  always_comb begin
    remaining_d = remaining_q;
    open_d      = open_q;
    if (accept) begin
      if (in_word_i.command == CMD_START) begin
        remaining_d = in_word_i.pay_len;
        open_d      = (in_word_i.pay_len != 63'd0);
      end else if (open_q) begin
        remaining_d = remaining_q - 63'd1;
        open_d      = (remaining_q != 63'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      open_q      <= 1'b0;
    end else begin
      remaining_q <= remaining_d;
      open_q      <= open_d;
    end
  end

endmodule

// File: hw/rtl/wsfhb_queue.sv
// Short job queue that decouples the front end from the byte emitter.
`timescale 1ns / 1ps

module wsfhb_queue import wsfhb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output job_t head_o
);

  job_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slots_q[rd_ptr_q];

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/wsfhb_back.sv
// Back end: walks each queued job byte by byte into the output register.
`timescale 1ns / 1ps

module wsfhb_back import wsfhb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  job_t      head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_word_q, out_word_d;
  logic             load;
  logic             job_last;
  logic [IDX_W-1:0] len_bytes;
  logic [IDX_W-1:0] end_idx;
  logic [IDX_W-1:0] sel;
  logic [5:0]       shamt;
  logic [7:0]       hdr_byte;

  assign load = head_valid_i && (!out_valid_q || out_ready_i);

  // Select the current header byte from the byte index.
  always_comb begin
    case (head_i.form)
      LEN_FORM7:  len_bytes = IDX_W'(1);
      LEN_FORM16: len_bytes = IDX_W'(3);
      LEN_FORM64: len_bytes = IDX_W'(9);
      default:    len_bytes = IDX_W'(1);
    endcase
    end_idx  = len_bytes + (head_i.is_close ? IDX_W'(CLOSE_EXTRA) : '0);
    sel      = IDX_W'(9) - idx_q;
    shamt    = {sel[2:0], 3'b000};
    hdr_byte = head_i.close_code[7:0];
    if (idx_q == '0) begin
      hdr_byte = FIN_BIT | {4'b0000, head_i.opcode};
    end else if (idx_q <= len_bytes) begin
      case (head_i.form)
        LEN_FORM7: begin
          hdr_byte = head_i.hlen[7:0];
        end
        LEN_FORM16: begin
          if (idx_q == IDX_W'(1)) begin
            hdr_byte = LEN16_MARK;
          end else if (idx_q == IDX_W'(2)) begin
            hdr_byte = head_i.hlen[15:8];
          end else begin
            hdr_byte = head_i.hlen[7:0];
          end
        end
        LEN_FORM64: begin
          if (idx_q == IDX_W'(1)) begin
            hdr_byte = LEN64_MARK;
          end else begin
            hdr_byte = 8'(head_i.hlen >> shamt);
          end
        end
        default: begin
          hdr_byte = head_i.hlen[7:0];
        end
      endcase
    end else if (idx_q == len_bytes + IDX_W'(1)) begin
      hdr_byte = head_i.close_code[15:8];
    end
  end

  // Output register, index and queue pop.
  always_comb begin
    if (head_i.kind == JOB_DATA) begin
      job_last                = 1'b1;
      out_word_d.out_byte     = head_i.data_byte;
      out_word_d.frame_end    = head_i.frame_end;
    end else begin
      job_last                = (idx_q == end_idx);
      out_word_d.out_byte     = hdr_byte;
      out_word_d.frame_end    = job_last && head_i.empty;
    end
    out_word_d.last = job_last;

    pop_o       = load && job_last;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = job_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_q <= out_word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// File: hw/rtl/websocket_frame_header_builder_unit.sv
// The first byte of a word passes through the job queue and then the output register.
// Payload bytes flow one per cycle while out_ready_i is held high; a start word holds the emitter
// for its 2 to 12 header bytes, while the two-entry job queue takes one more word.
// Reset empties the queue, clears the output valid flag and the frame state: no frame is open.
// Top level of the unmasked WebSocket frame header builder.
`timescale 1ns / 1ps

module websocket_frame_header_builder_unit import wsfhb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic push;
  job_t push_job;
  logic full;
  logic pop;
  logic head_valid;
  job_t head;

  // Word intake and classification.
  wsfhb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Job queue.
  wsfhb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Byte emitter.
  wsfhb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

`ifndef SYNTHESIS
  // The queue is never written while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("job pushed into a full queue");

  // The emitter only retires a job that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> head_valid)
    else $error("job popped from an empty queue");

  // A frame can only end on the last byte of a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.frame_end |-> out_word_o.last)
    else $error("frame end flagged on a byte that is not the last of its word");
`endif

endmodule
